/* design/psrp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psrp_pkg
// Shared widths, defaults, types and phase codes of the serial register port
// ----------------------------------------------------------------------------
package psrp_pkg;

  localparam int unsigned DATA_BITS_DEF  = 24;
  localparam int unsigned ADDR_BITS_DEF  = 6;

  localparam int unsigned DATA_W         = 24;
  localparam int unsigned ADDR_W         = 6;
  localparam int unsigned TICK_W         = 16;
  localparam logic [TICK_W-1:0] UNIT_TICKS_RST = 16'd50;

  typedef enum logic [6:0] {
    PH_IDLE   = 7'b0000001,
    PH_WR     = 7'b0000010,
    PH_RWAIT1 = 7'b0000100,
    PH_RADDR  = 7'b0001000,
    PH_RWAIT2 = 7'b0010000,
    PH_RDATA  = 7'b0100000,
    PH_SEN    = 7'b1000000
  } phase_e;

  typedef struct packed {
    logic              start_req;
    logic              req_type;
    logic [ADDR_W-1:0] reg_addr;
    logic [DATA_W-1:0] write_data;
    logic              sdo_level;
  } req_t;

  typedef struct packed {
    logic              sck_level;
    logic              sdi_level;
    logic              sen_level;
    logic              busy_res;
    logic              read_valid;
    logic [DATA_W-1:0] read_data;
  } res_t;

endpackage

/* design/psrp_channels.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psrp channels
// Valid/ready channel interfaces for request ticks and result ticks
// ----------------------------------------------------------------------------
interface psrp_req_if;
  logic           valid;
  logic           ready;
  psrp_pkg::req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface psrp_res_if;
  logic           valid;
  logic           ready;
  psrp_pkg::res_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

/* design/pll_serial_register_port.sv */
`timescale 1ns / 1ps
// the result of an accepted request tick is written into the output register
// throughput: one request tick per cycle while the receiver takes results, set by the engine step
// a result waiting in the output register does not stop the next request if it is taken
// reset: asynchronous active low, engine idle, pins low, unit_ticks back to 50
// ----------------------------------------------------------------------------
// pll_serial_register_port
// Serial register port master for a pll chip, one request transaction per tick
// ----------------------------------------------------------------------------
module pll_serial_register_port #(
  parameter int unsigned DATA_BITS = psrp_pkg::DATA_BITS_DEF,
  parameter int unsigned ADDR_BITS = psrp_pkg::ADDR_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [psrp_pkg::TICK_W-1:0] cfg_wdata_i,
  psrp_req_if.sink                    req_i,
  psrp_res_if.source                  res_o
);

  logic [psrp_pkg::TICK_W-1:0] unit_ticks_q;
  logic                        out_valid_q;
  psrp_pkg::res_t              out_q;
  psrp_pkg::res_t              step_res;
  logic                        accept;

  assign req_i.ready = !out_valid_q || res_o.ready;
  assign accept      = req_i.valid && req_i.ready;

  psrp_engine #(
    .DATA_BITS (DATA_BITS),
    .ADDR_BITS (ADDR_BITS)
  ) u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (accept),
    .req_i        (req_i.payload),
    .unit_ticks_i (unit_ticks_q),
    .res_o        (step_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unit_ticks_q <= psrp_pkg::UNIT_TICKS_RST;
    end else if (cfg_we_i) begin
      unit_ticks_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= step_res;
    end
  end

  assign res_o.valid   = out_valid_q;
  assign res_o.payload = out_q;

endmodule

/* design/psrp_engine.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psrp_engine
// Per-tick serializer state and pin sequencing for register writes and reads
// ----------------------------------------------------------------------------
module psrp_engine #(
  parameter int unsigned DATA_BITS = psrp_pkg::DATA_BITS_DEF,
  parameter int unsigned ADDR_BITS = psrp_pkg::ADDR_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          step_i,
  input  psrp_pkg::req_t                req_i,
  input  logic [psrp_pkg::TICK_W-1:0]   unit_ticks_i,
  output psrp_pkg::res_t                res_o
);

  localparam int unsigned WrBits   = ADDR_BITS + DATA_BITS + 2;
  localparam int unsigned RdABits  = ADDR_BITS + 1;
  localparam int unsigned CntW     = $clog2(WrBits + 1);
  localparam logic [CntW-1:0] WrLast   = CntW'(WrBits - 1);
  localparam logic [CntW-1:0] RdALast  = CntW'(RdABits - 1);
  localparam logic [CntW-1:0] DataLast = CntW'(DATA_BITS - 1);
  localparam int unsigned TW = psrp_pkg::TICK_W;

  psrp_pkg::phase_e     phase_q, phase_d;
  logic                 is_read_q, is_read_d;
  logic [WrBits-1:0]    shift_out_q, shift_out_d;
  logic [DATA_BITS-1:0] shift_in_q, shift_in_d;
  logic [CntW-1:0]      bit_count_q, bit_count_d;
  logic [1:0]           unit_step_q, unit_step_d;
  logic [TW-1:0]        tick_count_q, tick_count_d;
  logic [2:0]           pin_q, pin_d;

  logic [TW-1:0]        ut;
  logic                 last;
  logic                 busy;
  logic                 sck, sdi, sen, valid;
  logic [ADDR_BITS-1:0] addr;
  logic [DATA_BITS-1:0] data;

  assign ut   = (unit_ticks_i == '0) ? TW'(1) : unit_ticks_i;
  assign addr = ADDR_BITS'(req_i.reg_addr);
  assign data = DATA_BITS'(req_i.write_data);

  always_comb begin
    phase_d      = phase_q;
    is_read_d    = is_read_q;
    shift_out_d  = shift_out_q;
    shift_in_d   = shift_in_q;
    bit_count_d  = bit_count_q;
    unit_step_d  = unit_step_q;
    tick_count_d = tick_count_q;
    pin_d        = pin_q;
    valid        = 1'b0;
    last         = 1'b0;

    // start is taken on the same tick
    if (phase_q == psrp_pkg::PH_IDLE && req_i.start_req) begin
      is_read_d    = req_i.req_type;
      tick_count_d = '0;
      unit_step_d  = '0;
      bit_count_d  = '0;
      shift_in_d   = '0;
      if (req_i.req_type) begin
        shift_out_d = {1'b1, addr, {(DATA_BITS + 1){1'b0}}};
        phase_d     = psrp_pkg::PH_RWAIT1;
      end else begin
        shift_out_d = {1'b0, addr, data, 1'b0};
        phase_d     = psrp_pkg::PH_WR;
      end
    end

    busy = phase_d != psrp_pkg::PH_IDLE;
    sck  = pin_q[0];
    sdi  = pin_q[1];
    sen  = pin_q[2];

    if (busy) begin
      sck = 1'b0;
      sen = 1'b1;
      case (phase_d)
        psrp_pkg::PH_WR: begin
          sck = unit_step_d == 2'd1;
          sdi = shift_out_d[WrBits-1];
        end
        psrp_pkg::PH_RADDR: begin
          sck = unit_step_d == 2'd0;
          sdi = shift_out_d[WrBits-1];
        end
        psrp_pkg::PH_RDATA: begin
          sck = unit_step_d == 2'd0;
        end
        psrp_pkg::PH_SEN: begin
          sen = unit_step_d == 2'd1;
        end
        default: begin
        end
      endcase

      last = ({1'b0, tick_count_d} + (TW + 1)'(1)) >= {1'b0, ut};
      if (!last) begin
        tick_count_d = tick_count_d + TW'(1);
      end else begin
        tick_count_d = '0;
        case (phase_d)
          psrp_pkg::PH_WR: begin
            if (unit_step_d == 2'd2) begin
              unit_step_d = '0;
              shift_out_d = {shift_out_d[WrBits-2:0], 1'b0};
              if (bit_count_d == WrLast) begin
                bit_count_d = '0;
                phase_d     = psrp_pkg::PH_SEN;
              end else begin
                bit_count_d = bit_count_d + CntW'(1);
              end
            end else begin
              unit_step_d = unit_step_d + 2'd1;
            end
          end
          psrp_pkg::PH_RWAIT1: begin
            phase_d     = psrp_pkg::PH_RADDR;
            unit_step_d = '0;
            bit_count_d = '0;
          end
          psrp_pkg::PH_RADDR: begin
            if (unit_step_d == 2'd0) begin
              unit_step_d = 2'd1;
            end else begin
              unit_step_d = '0;
              shift_out_d = {shift_out_d[WrBits-2:0], 1'b0};
              if (bit_count_d == RdALast) begin
                bit_count_d = '0;
                phase_d     = psrp_pkg::PH_RWAIT2;
              end else begin
                bit_count_d = bit_count_d + CntW'(1);
              end
            end
          end
          psrp_pkg::PH_RWAIT2: begin
            phase_d     = psrp_pkg::PH_RDATA;
            unit_step_d = '0;
            bit_count_d = '0;
          end
          psrp_pkg::PH_RDATA: begin
            if (unit_step_d == 2'd0) begin
              unit_step_d = 2'd1;
            end else begin
              unit_step_d = '0;
              shift_in_d  = {shift_in_d[DATA_BITS-2:0], req_i.sdo_level};
              if (bit_count_d == DataLast) begin
                bit_count_d = '0;
                phase_d     = psrp_pkg::PH_SEN;
              end else begin
                bit_count_d = bit_count_d + CntW'(1);
              end
            end
          end
          psrp_pkg::PH_SEN: begin
            if (unit_step_d == 2'd2) begin
              unit_step_d = '0;
              phase_d     = psrp_pkg::PH_IDLE;
              valid       = is_read_d;
            end else begin
              unit_step_d = unit_step_d + 2'd1;
            end
          end
          default: begin
            phase_d = psrp_pkg::PH_IDLE;
          end
        endcase
      end
      pin_d = {sen, sdi, sck};
    end
  end

  always_comb begin
    res_o.sck_level  = sck;
    res_o.sdi_level  = sdi;
    res_o.sen_level  = sen;
    res_o.busy_res   = busy;
    res_o.read_valid = valid;
    res_o.read_data  = valid ? psrp_pkg::DATA_W'(shift_in_d) : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= psrp_pkg::PH_IDLE;
      is_read_q    <= 1'b0;
      shift_out_q  <= '0;
      shift_in_q   <= '0;
      bit_count_q  <= '0;
      unit_step_q  <= '0;
      tick_count_q <= '0;
      pin_q        <= '0;
    end else if (step_i) begin
      phase_q      <= phase_d;
      is_read_q    <= is_read_d;
      shift_out_q  <= shift_out_d;
      shift_in_q   <= shift_in_d;
      bit_count_q  <= bit_count_d;
      unit_step_q  <= unit_step_d;
      tick_count_q <= tick_count_d;
      pin_q        <= pin_d;
    end
  end

endmodule

/* tb/sv/tb_pll_serial_register_port.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pll_serial_register_port
// Tick-level check of the pll serial register port. Every accepted request
// tick is run through a local model of the pin engine. Each result tick is
// compared field by field with the levels and read word that the model
// gives. Covered: write and read frames, the unit length register from its
// reset value to both extremes, and changes to it in the middle of a unit.
// Also covered: starts while busy, random idling on both sides, and a long
// hold-off at the receiver.
// ----------------------------------------------------------------------------
module tb_pll_serial_register_port;

  localparam int unsigned WR_BITS     = psrp_pkg::ADDR_W + psrp_pkg::DATA_W + 2;
  localparam int unsigned RA_BITS     = psrp_pkg::ADDR_W + 1;
  localparam logic        OP_WRITE    = 1'b0;
  localparam logic        OP_READ     = 1'b1;
  localparam int          SDO_LOW     = 0;
  localparam int          SDO_HIGH    = 1;
  localparam int          SDO_RAND    = 2;
  localparam int          SDO_TOGGLE  = 3;
  localparam int unsigned NO_LIMIT    = 32'hFFFF_FFFF;
  localparam int unsigned HOLD_CYCLES = 48;

  logic                        clk = 1'b0;
  logic                        rst_n;
  logic                        cfg_we;
  logic [psrp_pkg::TICK_W-1:0] cfg_wdata;

  psrp_req_if req_if ();
  psrp_res_if res_if ();

  pll_serial_register_port DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .req_i       (req_if),
    .res_o       (res_if)
  );

  // local copy of the pin engine
  logic [psrp_pkg::TICK_W-1:0] unit_len;
  psrp_pkg::phase_e            m_phase;
  logic                        m_is_read;
  logic [WR_BITS-1:0]          m_shift_out;
  logic [psrp_pkg::DATA_W-1:0] m_shift_in;
  int unsigned                 m_bits;
  logic [1:0]                  m_step;
  logic [psrp_pkg::TICK_W-1:0] m_ticks;
  logic                        pin_sck;
  logic                        pin_sdi;
  logic                        pin_sen;

  psrp_pkg::res_t owed_levels[$];
  int unsigned    frames_done;
  int unsigned    ticks_sent;
  int unsigned    err_count;
  bit             src_offering;
  bit             src_calm;
  bit             sink_calm;
  bit             hold_pending;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic psrp_pkg::res_t port_tick(input psrp_pkg::req_t r);
    psrp_pkg::res_t o;
    logic [16:0]    ut;
    logic           sck;
    logic           sdi;
    logic           sen;
    logic           busy;
    logic           last;
    o   = '0;
    ut  = (unit_len == '0) ? 17'd1 : {1'b0, unit_len};
    sdi = pin_sdi;
    if (m_phase == psrp_pkg::PH_IDLE && r.start_req) begin
      m_is_read  = r.req_type;
      m_ticks    = '0;
      m_step     = '0;
      m_bits     = 0;
      m_shift_in = '0;
      if (r.req_type == OP_WRITE) begin
        m_shift_out = {1'b0, r.reg_addr, r.write_data, 1'b0};
        m_phase     = psrp_pkg::PH_WR;
      end else begin
        m_shift_out = {1'b1, r.reg_addr, {(WR_BITS - RA_BITS){1'b0}}};
        m_phase     = psrp_pkg::PH_RWAIT1;
      end
    end
    busy = (m_phase != psrp_pkg::PH_IDLE);
    sck  = pin_sck;
    sen  = pin_sen;
    if (busy) begin
      sck = 1'b0;
      sen = 1'b1;
      case (m_phase)
        psrp_pkg::PH_WR: begin
          sck = (m_step == 2'd1);
          sdi = m_shift_out[WR_BITS-1];
        end
        psrp_pkg::PH_RADDR: begin
          sck = (m_step == 2'd0);
          sdi = m_shift_out[WR_BITS-1];
        end
        psrp_pkg::PH_RDATA: begin
          sck = (m_step == 2'd0);
        end
        psrp_pkg::PH_SEN: begin
          sen = (m_step == 2'd1);
        end
        default: ;
      endcase
      last = ({1'b0, m_ticks} + 17'd1) >= ut;
      if (!last) begin
        m_ticks = m_ticks + 1'b1;
      end else begin
        m_ticks = '0;
        case (m_phase)
          psrp_pkg::PH_WR: begin
            if (m_step == 2'd2) begin
              m_step      = '0;
              m_shift_out = m_shift_out << 1;
              m_bits++;
              if (m_bits >= WR_BITS) begin
                m_bits  = 0;
                m_phase = psrp_pkg::PH_SEN;
              end
            end else begin
              m_step = m_step + 2'd1;
            end
          end
          psrp_pkg::PH_RWAIT1: begin
            m_phase = psrp_pkg::PH_RADDR;
            m_step  = '0;
            m_bits  = 0;
          end
          psrp_pkg::PH_RADDR: begin
            if (m_step == 2'd0) begin
              m_step = 2'd1;
            end else begin
              m_step      = '0;
              m_shift_out = m_shift_out << 1;
              m_bits++;
              if (m_bits >= RA_BITS) begin
                m_bits  = 0;
                m_phase = psrp_pkg::PH_RWAIT2;
              end
            end
          end
          psrp_pkg::PH_RWAIT2: begin
            m_phase = psrp_pkg::PH_RDATA;
            m_step  = '0;
            m_bits  = 0;
          end
          psrp_pkg::PH_RDATA: begin
            if (m_step == 2'd0) begin
              m_step = 2'd1;
            end else begin
              m_step     = '0;
              m_shift_in = {m_shift_in[psrp_pkg::DATA_W-2:0], r.sdo_level};
              m_bits++;
              if (m_bits >= psrp_pkg::DATA_W) begin
                m_bits  = 0;
                m_phase = psrp_pkg::PH_SEN;
              end
            end
          end
          psrp_pkg::PH_SEN: begin
            if (m_step == 2'd2) begin
              m_step  = '0;
              m_phase = psrp_pkg::PH_IDLE;
              frames_done++;
              if (m_is_read) begin
                o.read_valid = 1'b1;
                o.read_data  = m_shift_in;
              end
            end else begin
              m_step = m_step + 2'd1;
            end
          end
          default: begin
            m_phase = psrp_pkg::PH_IDLE;
          end
        endcase
      end
      pin_sck = sck;
      pin_sdi = sdi;
      pin_sen = sen;
    end
    o.sck_level = sck;
    o.sdi_level = sdi;
    o.sen_level = sen;
    o.busy_res  = busy;
    return o;
  endfunction

  function automatic psrp_pkg::req_t make_req(input logic start, input logic op,
                                              input logic [psrp_pkg::ADDR_W-1:0] addr,
                                              input logic [psrp_pkg::DATA_W-1:0] data,
                                              input logic sdo);
    psrp_pkg::req_t r;
    r.start_req  = start;
    r.req_type   = op;
    r.reg_addr   = addr;
    r.write_data = data;
    r.sdo_level  = sdo;
    return r;
  endfunction

  function automatic psrp_pkg::req_t rand_req(input bit start);
    psrp_pkg::req_t r;
    r.start_req  = start;
    r.req_type   = 1'($urandom_range(1));
    r.reg_addr   = psrp_pkg::ADDR_W'($urandom_range((1 << psrp_pkg::ADDR_W) - 1));
    r.write_data = psrp_pkg::DATA_W'($urandom_range((1 << psrp_pkg::DATA_W) - 1));
    r.sdo_level  = 1'($urandom_range(1));
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    err_count++;
    if (err_count <= 50) begin
      $display("%0t ns: %s mismatch, got %0h expected %0h", $time, what, got, want);
    end
  endtask

  task automatic send_tick(input psrp_pkg::req_t r);
    req_if.valid   <= 1'b1;
    req_if.payload <= r;
    src_offering    = 1'b1;
    forever begin
      @(posedge clk);
      if (req_if.valid && req_if.ready) break;
    end
    owed_levels.push_back(port_tick(r));
    ticks_sent++;
    if (!src_calm && $urandom_range(99) < 35) begin
      req_if.valid <= 1'b0;
      src_offering  = 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
  endtask

  task automatic wait_results_in;
    if (src_offering) begin
      req_if.valid <= 1'b0;
      src_offering  = 1'b0;
    end
    while (owed_levels.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic set_unit_len(input logic [psrp_pkg::TICK_W-1:0] v);
    wait_results_in();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we   <= 1'b0;
    unit_len  = v;
  endtask

  // keeps ticking the running frame, with starts offered while busy if poke is set
  task automatic follow_frame(input int sdo_mode, input bit poke, input int unsigned limit);
    psrp_pkg::req_t r;
    int unsigned    n;
    n = 0;
    while (m_phase != psrp_pkg::PH_IDLE && n < limit) begin
      r = rand_req(poke);
      case (sdo_mode)
        SDO_LOW:    r.sdo_level = 1'b0;
        SDO_HIGH:   r.sdo_level = 1'b1;
        SDO_TOGGLE: r.sdo_level = n[0];
        default: ;
      endcase
      send_tick(r);
      n++;
    end
  endtask

  task automatic test_reset_unit;
    send_tick(make_req(1'b1, OP_WRITE, 6'h2A, 24'h5A_5A5A, 1'b0));
    follow_frame(SDO_RAND, 1'b0, 160);
    // unit ends at once since the elapsed count is past the new length
    set_unit_len(16'd1);
    follow_frame(SDO_RAND, 1'b1, NO_LIMIT);
  endtask

  task automatic test_directed_frames;
    set_unit_len(16'd1);
    send_tick(make_req(1'b1, OP_WRITE, 6'h3F, 24'hFF_FFFF, 1'b1));
    follow_frame(SDO_HIGH, 1'b0, NO_LIMIT);
    send_tick(make_req(1'b1, OP_WRITE, 6'h00, 24'h00_0000, 1'b0));
    follow_frame(SDO_LOW, 1'b1, NO_LIMIT);
    send_tick(make_req(1'b1, OP_READ, 6'h3F, 24'hFF_FFFF, 1'b1));
    follow_frame(SDO_HIGH, 1'b1, NO_LIMIT);
    // idle tick, pins hold their levels
    send_tick(make_req(1'b0, OP_READ, 6'h3F, 24'hFF_FFFF, 1'b1));
    send_tick(make_req(1'b1, OP_READ, 6'h00, 24'h00_0000, 1'b0));
    follow_frame(SDO_LOW, 1'b0, NO_LIMIT);
    send_tick(make_req(1'b1, OP_READ, 6'h15, 24'h5A_A55A, 1'b1));
    follow_frame(SDO_TOGGLE, 1'b0, NO_LIMIT);
  endtask

  task automatic test_zero_unit;
    set_unit_len(16'd0);
    send_tick(make_req(1'b1, OP_WRITE, 6'h2A, 24'hA5_5AA5, 1'b0));
    follow_frame(SDO_RAND, 1'b0, NO_LIMIT);
    send_tick(make_req(1'b1, OP_READ, 6'h2A, 24'h12_3456, 1'b1));
    follow_frame(SDO_RAND, 1'b1, NO_LIMIT);
  endtask

  task automatic test_long_unit;
    set_unit_len(16'hFFFF);
    send_tick(make_req(1'b1, OP_READ, 6'h2A, 24'h00_0000, 1'b1));
    follow_frame(SDO_RAND, 1'b1, 200);
    set_unit_len(16'd2);
    follow_frame(SDO_RAND, 1'b0, NO_LIMIT);
  endtask

  task automatic test_backpressure;
    set_unit_len(16'd1);
    src_calm     = 1'b1;
    sink_calm    = 1'b1;
    hold_pending = 1'b1;
    send_tick(make_req(1'b1, OP_READ, 6'h33, 24'h00_0000, 1'b0));
    follow_frame(SDO_RAND, 1'b0, NO_LIMIT);
    send_tick(make_req(1'b1, OP_WRITE, 6'h0C, 24'hC3_3C96, 1'b1));
    follow_frame(SDO_RAND, 1'b0, 30);
    // sender stops until every result is back, mid frame
    wait_results_in();
    follow_frame(SDO_RAND, 1'b0, NO_LIMIT);
    src_calm  = 1'b0;
    sink_calm = 1'b0;
  endtask

  task automatic test_random_traffic;
    int unsigned                 seg;
    int unsigned                 base_ticks;
    int unsigned                 seg_frames;
    logic [psrp_pkg::TICK_W-1:0] len;
    psrp_pkg::req_t              r;
    seg        = 0;
    base_ticks = ticks_sent;
    while (ticks_sent - base_ticks < 450) begin
      case (seg % 5)
        0:       len = 16'd1;
        1:       len = 16'd2;
        2:       len = 16'd0;
        3:       len = 16'd3;
        default: len = 16'd1;
      endcase
      // register may change mid frame, the trailing ticks below can leave one running
      set_unit_len(len);
      src_calm   = (seg == 2);
      sink_calm  = (seg == 2);
      seg_frames = frames_done;
      while (frames_done == seg_frames) begin
        if (m_phase == psrp_pkg::PH_IDLE) begin
          r = rand_req($urandom_range(99) < 70);
        end else begin
          r = rand_req($urandom_range(99) < 15);
        end
        send_tick(r);
      end
      repeat ($urandom_range(40)) begin
        r = rand_req($urandom_range(99) < 50);
        send_tick(r);
      end
      seg++;
    end
    src_calm  = 1'b0;
    sink_calm = 1'b0;
  endtask

  always @(posedge clk) begin : level_check
    psrp_pkg::res_t want;
    if (rst_n && res_if.valid && res_if.ready) begin
      if (owed_levels.size() == 0) begin
        report_mismatch("unexpected transaction", 32'd0, 32'd0);
      end else begin
        want = owed_levels.pop_front();
        if (res_if.payload.sck_level !== want.sck_level)
          report_mismatch("sck_level", 32'(res_if.payload.sck_level),
                          32'(want.sck_level));
        if (res_if.payload.sdi_level !== want.sdi_level)
          report_mismatch("sdi_level", 32'(res_if.payload.sdi_level),
                          32'(want.sdi_level));
        if (res_if.payload.sen_level !== want.sen_level)
          report_mismatch("sen_level", 32'(res_if.payload.sen_level),
                          32'(want.sen_level));
        if (res_if.payload.busy_res !== want.busy_res)
          report_mismatch("busy_res", 32'(res_if.payload.busy_res),
                          32'(want.busy_res));
        if (res_if.payload.read_valid !== want.read_valid)
          report_mismatch("read_valid", 32'(res_if.payload.read_valid),
                          32'(want.read_valid));
        if (res_if.payload.read_data !== want.read_data)
          report_mismatch("read_data", 32'(res_if.payload.read_data),
                          32'(want.read_data));
      end
    end
  end

  initial begin : sink_side
    int unsigned n;
    res_if.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_pending) begin
        hold_pending = 1'b0;
        res_if.ready <= 1'b0;
        for (n = 0; n < HOLD_CYCLES; n++) @(posedge clk);
        res_if.ready <= 1'b1;
      end else if (sink_calm) begin
        res_if.ready <= 1'b1;
      end else begin
        res_if.ready <= ($urandom_range(99) >= 35);
      end
    end
  end

  initial begin : watchdog
    #2000000;
    $display("pll_serial_register_port verification failed");
    $finish;
  end

  initial begin : run_tests
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    req_if.valid   = 1'b0;
    req_if.payload = '0;
    src_offering   = 1'b0;
    src_calm       = 1'b0;
    sink_calm      = 1'b0;
    hold_pending   = 1'b0;
    err_count      = 0;
    frames_done    = 0;
    ticks_sent     = 0;
    unit_len       = psrp_pkg::UNIT_TICKS_RST;
    m_phase        = psrp_pkg::PH_IDLE;
    m_is_read      = 1'b0;
    m_shift_out    = '0;
    m_shift_in     = '0;
    m_bits         = 0;
    m_step         = '0;
    m_ticks        = '0;
    pin_sck        = 1'b0;
    pin_sdi        = 1'b0;
    pin_sen        = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_unit();
    test_directed_frames();
    test_zero_unit();
    test_long_unit();
    test_backpressure();
    test_random_traffic();
    wait_results_in();
    repeat (8) @(posedge clk);
    if (err_count == 0) begin
      $display("pll_serial_register_port verification clean");
    end else begin
      $display("pll_serial_register_port verification failed");
    end
    $finish;
  end

endmodule
